>>> src/sha256_pkg.sv
// Package: SHA-256 constants, command codes, sequencer states and round functions.
`timescale 1ns / 1ps
package sha256_pkg;

  typedef enum logic [1:0] {
    CMD_ABSORB        = 2'd0,
    CMD_ABSORB_FINISH = 2'd1,
    CMD_FINISH        = 2'd2,
    CMD_UNUSED        = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_EMIT
  } state_t;

  typedef logic [31:0] word_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned LEN_POS = 56;

  localparam word_t INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

>>> src/sha256_if.sv
// Interfaces: input request channel and digest result channel.
`timescale 1ns / 1ps
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  modport source (output valid, cmd, data_byte, input ready);
  modport sink   (input valid, cmd, data_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> src/sha256_stream_hasher.sv
// Top level: byte-stream SHA-256 hasher with one shared round unit.
`timescale 1ns / 1ps
// Requests carry a command and a byte. An absorb request that does not fill
// the 64-byte block is written to the buffer, and the next request can follow at once.
// A request that completes a block holds ready low while the block streams
// the 64 bytes through the registered buffer read port into the schedule
// window, runs the single shared round unit (one SHA-256 round and one
// message schedule word per cycle), and folds the result into the hash
// words. A finish request writes padding one byte per cycle from the 0x80
// position to the end of the block, compresses once, or twice when the 0x80
// byte leaves no room for the length field or when an absorb-and-finish byte
// fills the block, and then presents four 64-bit digest results, word 0
// first, the last one flagged by last_word; each result waits for
// out_res.ready. The block accepts no request while it works on one. The
// hash state then returns to the initial values for the next message.
// Command 3 is accepted and dropped silently.
module sha256_stream_hasher (
  input  logic                 clk,
  input  logic                 rst,
  sha256_in_if.sink            in_req,
  sha256_out_if.source         out_res
);
  import sha256_pkg::*;

  state_t state, state_next;

  logic [7:0]  block_buffer [64];
  logic [5:0]  fill_count;
  logic [63:0] message_bits;
  word_t       hash_words [8];

  // round working variables and a 16-deep schedule window
  word_t       v [8];
  word_t       w [16];
  logic [5:0]  round;
  logic        finishing;   // current compression belongs to a finish
  logic        second_pass; // padding needs another block after this one
  logic        pad_mark;    // the 0x80 byte is still to be written
  logic [6:0]  pad_pos;
  logic [1:0]  emit_idx;

  logic        buf_we;
  logic [5:0]  buf_wa;
  logic [7:0]  buf_wd;
  logic [5:0]  buf_ra;
  logic [7:0]  buf_rd;

  // Load fetches 64 bytes, one per cycle, through the registered read port.
  logic [6:0]  load_cnt;
  logic        rd_pending;

  logic        accept;
  cmd_t        cmd;
  word_t       t1, t2, w_cur, w_new;

  assign cmd    = cmd_t'(in_req.cmd);
  assign accept = in_req.valid && in_req.ready;

  // Buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (buf_we) begin
      block_buffer[buf_wa] <= buf_wd;
    end
    buf_rd <= block_buffer[buf_ra];
  end

  // next-state logic
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_ABSORB:        if (fill_count == 6'd63) state_next = ST_LOAD;
            CMD_ABSORB_FINISH: state_next = (fill_count == 6'd63) ? ST_LOAD : ST_PAD;
            CMD_FINISH:        state_next = ST_PAD;
            default:           state_next = ST_IDLE;
          endcase
        end
      end
      ST_PAD:    if (pad_pos == 7'd64) state_next = ST_LOAD;
      ST_LOAD:   if (load_cnt == 7'd64) state_next = ST_ROUND;
      ST_ROUND:  if (round == 6'd63) state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (finishing && (second_pass || pad_mark)) state_next = ST_PAD;
        else if (finishing)                         state_next = ST_EMIT;
        else                                        state_next = ST_IDLE;
      end
      ST_EMIT:   if (out_res.ready && emit_idx == 2'd3) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // output and buffer-port logic
  logic [7:0] pad_byte;
  logic [5:0] len_fill;
  always_comb begin
    in_req.ready = (state == ST_IDLE);
    out_res.valid = (state == ST_EMIT);
    out_res.digest_word = {hash_words[{emit_idx, 1'b0}], hash_words[{emit_idx, 1'b1}]};
    out_res.word_index = emit_idx;
    out_res.last_word = (emit_idx == 2'd3);

    len_fill = pad_pos[5:0] - 6'(LEN_POS);
    if (pad_mark) begin
      pad_byte = PAD_BYTE;
    end else if (pad_pos[5:0] >= 6'(LEN_POS) && !second_pass) begin
      pad_byte = message_bits[63 - {len_fill[2:0], 3'b000} -: 8];
    end else begin
      pad_byte = 8'h00;
    end

    buf_we = 1'b0;
    buf_wa = fill_count;
    buf_wd = in_req.data_byte;
    if (state == ST_IDLE && accept &&
        (cmd == CMD_ABSORB || cmd == CMD_ABSORB_FINISH)) begin
      buf_we = 1'b1;
    end else if (state == ST_PAD && pad_pos != 7'd64) begin
      buf_we = 1'b1;
      buf_wa = pad_pos[5:0];
      buf_wd = pad_byte;
    end
    buf_ra = load_cnt[5:0];
  end

  // round unit: the window always holds the current schedule word at w[0]
  assign w_cur = w[0];
  assign w_new = sig1(w[4'd14]) + w[4'd9] + sig0(w[4'd1]) + w[4'd0];
  assign t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[round] + w_cur;
  assign t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill_count   <= '0;
      message_bits <= '0;
      finishing    <= 1'b0;
      second_pass  <= 1'b0;
      pad_mark     <= 1'b0;
      pad_pos      <= '0;
      emit_idx     <= '0;
      round        <= '0;
      load_cnt     <= '0;
      rd_pending   <= 1'b0;
      for (int i = 0; i < 8; i++) hash_words[i] <= INIT_H[i];
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          load_cnt   <= '0;
          rd_pending <= 1'b0;
          if (accept && cmd != CMD_UNUSED) begin
            if (cmd != CMD_FINISH) begin
              fill_count   <= fill_count + 6'd1;
              message_bits <= message_bits + 64'd8;
            end
            finishing <= (cmd != CMD_ABSORB);
            pad_mark  <= (cmd != CMD_ABSORB);
            // position of the 0x80 byte, after this request's own byte if it has one
            if (cmd == CMD_FINISH) begin
              pad_pos     <= {1'b0, fill_count};
              second_pass <= (fill_count > 6'd55);
            end else begin
              pad_pos     <= 7'(fill_count) + 7'd1;
              second_pass <= (fill_count > 6'd54) && (fill_count != 6'd63);
            end
          end
        end
        ST_PAD: begin
          if (pad_pos != 7'd64) begin
            pad_pos  <= pad_pos + 7'd1;
            pad_mark <= 1'b0;
          end
          load_cnt   <= '0;
          rd_pending <= 1'b0;
        end
        ST_LOAD: begin
          if (load_cnt != 7'd64) load_cnt <= load_cnt + 7'd1;
          rd_pending <= (load_cnt != 7'd64);
          // shift each arriving byte into the window, big-endian words
          if (rd_pending) begin
            for (int i = 0; i < 15; i++) w[i] <= {w[i][23:0], w[i + 1][31:24]};
            w[15] <= {w[15][23:0], buf_rd};
          end
          round <= '0;
          for (int i = 0; i < 8; i++) v[i] <= hash_words[i];
        end
        ST_ROUND: begin
          round <= round + 6'd1;
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= w_new;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
        end
        ST_UPDATE: begin
          for (int i = 0; i < 8; i++) hash_words[i] <= hash_words[i] + v[i];
          if (finishing && (second_pass || pad_mark)) begin
            // another padding block: zeros (or 0x80) up to the length field
            second_pass <= 1'b0;
            pad_pos     <= '0;
          end
          if (!finishing) fill_count <= '0;
        end
        ST_EMIT: begin
          if (out_res.ready) begin
            emit_idx <= emit_idx + 2'd1;
            if (emit_idx == 2'd3) begin
              fill_count   <= '0;
              message_bits <= '0;
              finishing    <= 1'b0;
              for (int i = 0; i < 8; i++) hash_words[i] <= INIT_H[i];
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_req.ready)
    else $error("ready while busy");
  a_index_advance: assert property (@(posedge clk) disable iff (rst)
    (out_res.valid && out_res.ready && !out_res.last_word) |=>
      (out_res.word_index == $past(out_res.word_index) + 2'd1))
    else $error("digest index skipped");
  a_round_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && round == 6'd63) |=> (state == ST_UPDATE))
    else $error("round count wrong");
`endif

endmodule

>>> sim/sha256_stream_hasher_tb.sv
// Testbench for the byte-stream SHA-256 hasher: directed and random messages vs. a predictor.
`timescale 1ns / 1ps
module sha256_stream_hasher_tb;
  import sha256_pkg::*;

  typedef struct {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } digest_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   error_count = 0;

  sha256_in_if  in_req ();
  sha256_out_if out_res ();

  sha256_stream_hasher DUT (
    .clk     (clk),
    .rst     (rst),
    .in_req  (in_req.sink),
    .out_res (out_res.source)
  );

  always #4 clk = ~clk;

  // Predictor state: pending block, fill level, bit count and chaining value.
  logic [7:0]  blk_bytes [64];
  logic [5:0]  blk_fill;
  logic [63:0] msg_bits;
  word_t       chain_h [8];
  digest_t     digest_queue [$];

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    word_t w [64];
    word_t v [8];
    word_t s0, s1, t1, t2;
    for (int r = 0; r < 16; r++)
      w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
    for (int r = 16; r < 64; r++) begin
      s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = s1 + w[r-7] + s0 + w[r-16];
    end
    v = chain_h;
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int r = 0; r < 8; r++) chain_h[r] = chain_h[r] + v[r];
  endtask

  task automatic absorb_byte(logic [7:0] b);
    blk_bytes[blk_fill] = b;
    blk_fill = blk_fill + 6'd1;
    msg_bits = msg_bits + 64'd8;
    if (blk_fill == 6'd0) compress_block();
  endtask

  task automatic restart_message();
    blk_fill = '0;
    msg_bits = '0;
    chain_h = INIT_H;
  endtask

  // Pad, compress, queue the four digest quarters and restart.
  task automatic finish_message();
    int i;
    digest_t d;
    i = int'(blk_fill);
    blk_bytes[i++] = PAD_BYTE;
    if (i > LEN_POS) begin
      while (i < 64) blk_bytes[i++] = 8'h00;
      compress_block();
      i = 0;
    end
    while (i < LEN_POS) blk_bytes[i++] = 8'h00;
    for (int k = 0; k < 8; k++) blk_bytes[56 + k] = msg_bits[63 - 8*k -: 8];
    compress_block();
    for (int k = 0; k < 4; k++) begin
      d.digest_word = {chain_h[2*k], chain_h[2*k+1]};
      d.word_index  = k[1:0];
      d.last_word   = (k == 3);
      digest_queue.push_back(d);
    end
    restart_message();
  endtask

  task automatic predict_request(cmd_t c, logic [7:0] b);
    case (c)
      CMD_ABSORB: absorb_byte(b);
      CMD_ABSORB_FINISH: begin
        absorb_byte(b);
        finish_message();
      end
      CMD_FINISH: finish_message();
      default: ;
    endcase
  endtask

  // Present one request, hold until accepted, predict, then idle a random gap.
  task automatic send_request(cmd_t c, logic [7:0] b);
    int gap;
    in_req.valid     <= 1'b1;
    in_req.cmd       <= c;
    in_req.data_byte <= b;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    predict_request(c, b);
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message(int len, bit tail_byte, bit random_bytes, logic [7:0] fill);
    for (int i = 0; i < len; i++)
      send_request(CMD_ABSORB, random_bytes ? 8'($urandom) : fill);
    if (tail_byte) send_request(CMD_ABSORB_FINISH, random_bytes ? 8'($urandom) : fill);
    else send_request(CMD_FINISH, 8'($urandom));
  endtask

  // Drop valid and hold until every expected result has come.
  task automatic drain_digests();
    in_req.valid <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
  endtask

  // Empty message, both finish forms, byte extremes, dropped command 3.
  task automatic test_directed();
    send_request(CMD_FINISH, 8'h00);
    send_request(CMD_ABSORB_FINISH, 8'h00);
    send_request(CMD_ABSORB_FINISH, 8'hff);
    send_request(CMD_UNUSED, 8'h5a);
    send_request(CMD_ABSORB, 8'h61);
    send_request(CMD_UNUSED, 8'hff);
    send_request(CMD_ABSORB, 8'h62);
    send_request(CMD_ABSORB_FINISH, 8'h63);
    send_request(CMD_UNUSED, 8'h00);
    send_request(CMD_FINISH, 8'hff);
  endtask

  // Lengths around the padding boundaries: one or two final blocks.
  task automatic test_pad_boundaries();
    send_message(54, 1'b1, 1'b1, 8'h00);
    send_message(56, 1'b0, 1'b0, 8'hff);
    send_message(63, 1'b1, 1'b0, 8'h00);
    send_message(64, 1'b0, 1'b1, 8'h00);
    drain_digests();
  endtask

  // Random messages, mostly short, with noise of unused commands.
  task automatic test_random_messages();
    int len;
    int sent;
    sent = 0;
    while (sent < 170) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 12);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0) send_request(CMD_UNUSED, 8'($urandom));
        send_request(CMD_ABSORB, 8'($urandom));
      end
      if ($urandom_range(0, 1)) send_request(CMD_ABSORB_FINISH, 8'($urandom));
      else send_request(CMD_FINISH, 8'($urandom));
      sent += len + 1;
    end
  endtask

  // Result side: random stall, compare each digest quarter with the oldest expected.
  initial begin
    digest_t exp_d;
    int stall;
    out_res.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_res.ready <= 1'b1;
      @(posedge clk);
      while (!out_res.valid) @(posedge clk);
      if (digest_queue.size() == 0) begin
        $error("digest result with nothing expected: %h", out_res.digest_word);
        error_count++;
      end else begin
        exp_d = digest_queue.pop_front();
        if (out_res.digest_word !== exp_d.digest_word) begin
          $error("digest_word expected %h actual %h", exp_d.digest_word, out_res.digest_word);
          error_count++;
        end
        if (out_res.word_index !== exp_d.word_index) begin
          $error("word_index expected %0d actual %0d", exp_d.word_index, out_res.word_index);
          error_count++;
        end
        if (out_res.last_word !== exp_d.last_word) begin
          $error("last_word expected %0d actual %0d", exp_d.last_word, out_res.last_word);
          error_count++;
        end
      end
    end
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    in_req.valid     = 1'b0;
    in_req.cmd       = CMD_ABSORB;
    in_req.data_byte = 8'h00;
    blk_bytes = '{default: 8'h00};
    restart_message();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_pad_boundaries();
    test_random_messages();
    drain_digests();
    repeat (200) @(posedge clk);
    if (error_count == 0 && digest_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

>>> filelist.f
src/sha256_pkg.sv
src/sha256_if.sv
src/sha256_stream_hasher.sv
sim/sha256_stream_hasher_tb.sv
